### rtl/ref_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ref_pkg;

    localparam int RATE_EXTRA = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_FORCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEC_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEC_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VEC_Z       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_MODE = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SAT    = 2'd1;
    localparam logic [1:0] ST_CENTRE = 2'd2;

    typedef struct packed {
        logic [31:0]        step_count;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] energy;
        logic [1:0]         status;
    } t_out;

    // Side information that rides along the square root pipeline.
    typedef struct packed {
        logic signed [31:0] s;
        logic               sat_c;
        logic               zero;
        logic [2:0]         neg;
        logic [2:0][30:0]   e;
        logic               kneg;
        logic [4:0]         k;
        logic signed [31:0] dfx;
        logic signed [31:0] dfy;
        logic signed [31:0] dfz;
        logic signed [31:0] den;
        logic               dsat;
    } t_sq_tag;

    // Side information that rides along the divider pipeline.
    typedef struct packed {
        logic               s_neg;
        logic               sat_c;
        logic               zero;
        logic [2:0]         neg;
        logic signed [63:0] eprod;
        logic signed [31:0] dfx;
        logic signed [31:0] dfy;
        logic signed [31:0] dfz;
        logic signed [31:0] den;
        logic               dsat;
    } t_dv_tag;

    // Returns {overflow, value clamped to 32 signed bits}.
    function automatic logic [32:0] sat32(input logic signed [71:0] v);
        logic [32:0] res;
        if (v > 72'sd2147483647) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < -72'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/ramped_external_force_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ramped external force. Each item carries a step count and a particle position and yields
// one result item with the force vector, its potential energy and a status code. The block
// accepts one item per clock while the input is not stalled. Each item passes through the
// 32-stage square root for the centre distance and the 32-stage divider that normalizes the
// centre direction, with ten further stages for the ramp, products, scaling and final
// rounding. Both modes travel through the same stages, so results leave in order. The input
// stalls only while a result waits at the output. Configuration registers are to be written
// by the user only while no item is in flight; the block itself does not enforce this.

module ramped_external_force_core import ref_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int STEP_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out_data
);

    localparam int SW = (STEP_BITS < 32) ? STEP_BITS : 32;
    localparam int PW = 33 + SW;
    localparam logic signed [71:0] HALF_F = 72'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [71:0] HALF_R = 72'sd1 <<< (RATE_EXTRA - 1);

    logic signed [31:0] r_base;
    logic signed [31:0] r_rate;
    logic signed [31:0] r_vec_x;
    logic signed [31:0] r_vec_y;
    logic signed [31:0] r_vec_z;
    logic               r_mode;

    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_rate  <= '0;
            r_vec_x <= 32'(1) << FRAC_BITS;
            r_vec_y <= '0;
            r_vec_z <= '0;
            r_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BASE_FORCE:  r_base  <= i_cfg_data;
                REG_FORCE_RATE:  r_rate  <= i_cfg_data;
                REG_VEC_X:       r_vec_x <= i_cfg_data;
                REG_VEC_Y:       r_vec_y <= i_cfg_data;
                REG_VEC_Z:       r_vec_z <= i_cfg_data;
                REG_CENTRE_MODE: r_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage 1: ramp product, dot products, centre differences.
    logic                r_s1_v;
    logic signed [PW-1:0] r_s1_prate;
    logic signed [63:0]  r_s1_pd [3];
    logic signed [32:0]  r_s1_d  [3];

    // Stage 2: strength, dot sum, magnitudes.
    logic               r_s2_v;
    logic signed [31:0] r_s2_s;
    logic               r_s2_ssat;
    logic signed [31:0] r_s2_dot;
    logic               r_s2_dsat;
    logic [2:0]         r_s2_neg;
    logic [31:0]        r_s2_mag [3];
    logic [32:0]        n_s2_s;
    logic [32:0]        n_s2_dot;
    logic signed [32:0] n_s2_abs [3];

    // Stage 3: direction products, largest magnitude.
    logic               r_s3_v;
    logic signed [63:0] r_s3_fp [3];
    logic signed [63:0] r_s3_ep;
    logic signed [31:0] r_s3_s;
    logic               r_s3_ssat;
    logic               r_s3_dsat;
    logic [2:0]         r_s3_neg;
    logic [31:0]        r_s3_mag [3];
    logic [31:0]        r_s3_m;
    logic [31:0]        n_s3_m01;

    // Stage 4: direction results, normalizing shift.
    logic               r_s4_v;
    t_sq_tag            r_s4_tag;
    logic [31:0]        r_s4_mag [3];
    t_sq_tag            n_s4_tag;
    logic [32:0]        n_s4_f [3];
    logic [32:0]        n_s4_en;

    // Stages 5 to 7: scaled vector, squares, sum of squares.
    logic               r_s5_v;
    t_sq_tag            r_s5_tag;
    t_sq_tag            n_s5_tag;
    logic [31:0]        n_s5_sh [3];
    logic               r_s6_v;
    t_sq_tag            r_s6_tag;
    logic [61:0]        r_s6_sq [3];
    logic               r_s7_v;
    t_sq_tag            r_s7_tag;
    logic [63:0]        r_s7_sum;

    logic               sq_valid;
    logic [31:0]        sq_root;
    t_sq_tag            sq_tag;

    // Stage 8: distance and numerator products.
    logic               r_s8_v;
    t_sq_tag            r_s8_tag;
    logic [30:0]        r_s8_dist;
    logic [62:0]        r_s8_prod [3];
    logic [31:0]        r_s8_r;
    t_sq_tag            n_s8_tag;
    logic [32:0]        n_s8_dist;
    logic [32:0]        n_s8_rnd;
    logic [31:0]        n_s8_as;
    logic               n_s8_dsat;

    // Stage 9: divider operands and centre energy product.
    logic               r_s9_v;
    t_dv_tag            r_s9_tag;
    logic [2:0][63:0]   r_s9_num;
    logic [32:0]        r_s9_den;

    logic               dv_valid;
    logic [2:0][31:0]   dv_quo;
    t_dv_tag            dv_tag;

    logic               r_out_v;
    t_out               r_out;
    t_out               n_out;
    logic [32:0]        n_cf [3];
    logic [32:0]        n_cen;
    logic               n_flip;
    logic               n_csat;

    assign o_in_stall = r_out_v & i_out_stall;
    assign en         = ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_s9_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_in_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_s6_v  <= r_s5_v;
            r_s7_v  <= r_s6_v;
            r_s8_v  <= sq_valid;
            r_s9_v  <= r_s8_v;
            r_out_v <= dv_valid;
        end
    end

    always_comb begin
        n_s2_s   = sat32(((72'(r_s1_prate) + HALF_R) >>> RATE_EXTRA) + 72'(r_base));
        n_s2_dot = sat32((72'(r_s1_pd[0]) + 72'(r_s1_pd[1]) + 72'(r_s1_pd[2]) + HALF_F)
                         >>> FRAC_BITS);
        for (int i = 0; i < 3; i++) begin
            n_s2_abs[i] = r_s1_d[i][32] ? -r_s1_d[i] : r_s1_d[i];
        end
        n_s3_m01 = (r_s2_mag[0] > r_s2_mag[1]) ? r_s2_mag[0] : r_s2_mag[1];
    end

    always_comb begin
        n_s4_tag = '0;
        for (int i = 0; i < 3; i++) begin
            n_s4_f[i] = sat32((72'(r_s3_fp[i]) + HALF_F) >>> FRAC_BITS);
        end
        n_s4_en = sat32(-((72'(r_s3_ep) + HALF_F) >>> FRAC_BITS));
        n_s4_tag.s     = r_s3_s;
        n_s4_tag.sat_c = r_s3_ssat;
        n_s4_tag.zero  = (r_s3_m == '0);
        n_s4_tag.neg   = r_s3_neg;
        n_s4_tag.kneg  = r_s3_m[31];
        for (int i = 0; i < 31; i++) begin
            if (r_s3_m[i]) begin
                n_s4_tag.k = 5'(30 - i);
            end
        end
        n_s4_tag.dfx  = n_s4_f[0][31:0];
        n_s4_tag.dfy  = n_s4_f[1][31:0];
        n_s4_tag.dfz  = n_s4_f[2][31:0];
        n_s4_tag.den  = n_s4_en[31:0];
        n_s4_tag.dsat = r_s3_ssat | r_s3_dsat | n_s4_f[0][32] | n_s4_f[1][32]
                        | n_s4_f[2][32] | n_s4_en[32];
    end

    always_comb begin
        n_s5_tag = r_s4_tag;
        for (int i = 0; i < 3; i++) begin
            n_s5_sh[i] = r_s4_mag[i] << r_s4_tag.k;
            n_s5_tag.e[i] = r_s4_tag.kneg ? r_s4_mag[i][31:1] : n_s5_sh[i][30:0];
        end
    end

    always_comb begin
        n_s8_as  = sq_tag.s[31] ? 32'(-sq_tag.s) : 32'(sq_tag.s);
        n_s8_rnd = (sq_tag.k == '0) ? '0 : (33'd1 << (sq_tag.k - 5'd1));
        if (sq_tag.kneg) begin
            n_s8_dist = {sq_root, 1'b0};
        end else begin
            n_s8_dist = ({1'b0, sq_root} + n_s8_rnd) >> sq_tag.k;
        end
        n_s8_dsat = (n_s8_dist > 33'h0_7fff_ffff);
        n_s8_tag       = sq_tag;
        n_s8_tag.sat_c = sq_tag.sat_c | n_s8_dsat;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_prate <= r_rate * $signed({1'b0, i_in_data.step_count[SW-1:0]});
            r_s1_pd[0] <= i_in_data.pos_x * r_vec_x;
            r_s1_pd[1] <= i_in_data.pos_y * r_vec_y;
            r_s1_pd[2] <= i_in_data.pos_z * r_vec_z;
            r_s1_d[0]  <= 33'(r_vec_x) - 33'(i_in_data.pos_x);
            r_s1_d[1]  <= 33'(r_vec_y) - 33'(i_in_data.pos_y);
            r_s1_d[2]  <= 33'(r_vec_z) - 33'(i_in_data.pos_z);

            r_s2_s    <= n_s2_s[31:0];
            r_s2_ssat <= n_s2_s[32];
            r_s2_dot  <= n_s2_dot[31:0];
            r_s2_dsat <= n_s2_dot[32];
            for (int i = 0; i < 3; i++) begin
                r_s2_neg[i] <= r_s1_d[i][32];
                r_s2_mag[i] <= n_s2_abs[i][31:0];
            end

            r_s3_fp[0] <= r_s2_s * r_vec_x;
            r_s3_fp[1] <= r_s2_s * r_vec_y;
            r_s3_fp[2] <= r_s2_s * r_vec_z;
            r_s3_ep    <= r_s2_s * r_s2_dot;
            r_s3_s     <= r_s2_s;
            r_s3_ssat  <= r_s2_ssat;
            r_s3_dsat  <= r_s2_dsat;
            r_s3_neg   <= r_s2_neg;
            r_s3_mag   <= r_s2_mag;
            r_s3_m     <= (n_s3_m01 > r_s2_mag[2]) ? n_s3_m01 : r_s2_mag[2];

            r_s4_tag <= n_s4_tag;
            r_s4_mag <= r_s3_mag;

            r_s5_tag <= n_s5_tag;

            r_s6_tag <= r_s5_tag;
            for (int i = 0; i < 3; i++) begin
                r_s6_sq[i] <= 62'(r_s5_tag.e[i]) * 62'(r_s5_tag.e[i]);
            end

            r_s7_tag <= r_s6_tag;
            r_s7_sum <= 64'(r_s6_sq[0]) + 64'(r_s6_sq[1]) + 64'(r_s6_sq[2]);

            r_s8_tag       <= n_s8_tag;
            r_s8_dist      <= n_s8_dsat ? 31'h7fff_ffff : n_s8_dist[30:0];
            r_s8_r         <= sq_root;
            for (int i = 0; i < 3; i++) begin
                r_s8_prod[i] <= 63'(n_s8_as) * 63'(sq_tag.e[i]);
            end

            r_s9_tag.s_neg <= r_s8_tag.s[31];
            r_s9_tag.sat_c <= r_s8_tag.sat_c;
            r_s9_tag.zero  <= r_s8_tag.zero;
            r_s9_tag.neg   <= r_s8_tag.neg;
            r_s9_tag.eprod <= r_s8_tag.s * $signed({1'b0, r_s8_dist});
            r_s9_tag.dfx   <= r_s8_tag.dfx;
            r_s9_tag.dfy   <= r_s8_tag.dfy;
            r_s9_tag.dfz   <= r_s8_tag.dfz;
            r_s9_tag.den   <= r_s8_tag.den;
            r_s9_tag.dsat  <= r_s8_tag.dsat;
            for (int i = 0; i < 3; i++) begin
                r_s9_num[i] <= {r_s8_prod[i], 1'b0} + 64'(r_s8_r);
            end
            r_s9_den <= {r_s8_r, 1'b0};

            r_out <= n_out;
        end
    end

    ref_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s7_v),
        .i_rad   (r_s7_sum),
        .i_tag   (r_s7_tag),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    ref_divu u_divu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s9_v),
        .i_num   (r_s9_num),
        .i_den   (r_s9_den),
        .i_tag   (r_s9_tag),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_tag   (dv_tag)
    );

    always_comb begin
        n_out  = '0;
        n_flip = 1'b0;
        n_cen  = sat32(-((72'(dv_tag.eprod) + HALF_F) >>> FRAC_BITS));
        n_csat = dv_tag.sat_c | n_cen[32];
        for (int i = 0; i < 3; i++) begin
            n_flip = dv_tag.s_neg ^ dv_tag.neg[i];
            if (n_flip) begin
                n_cf[i] = {1'b0, 32'(-dv_quo[i])};
            end else if (dv_quo[i][31]) begin
                n_cf[i] = {1'b1, 32'h7fff_ffff};
            end else begin
                n_cf[i] = {1'b0, dv_quo[i]};
            end
            n_csat = n_csat | n_cf[i][32];
        end
        if (!r_mode) begin
            n_out.force_x = dv_tag.dfx;
            n_out.force_y = dv_tag.dfy;
            n_out.force_z = dv_tag.dfz;
            n_out.energy  = dv_tag.den;
            n_out.status  = dv_tag.dsat ? ST_SAT : ST_OK;
        end else if (dv_tag.zero) begin
            n_out.status = ST_CENTRE;
        end else begin
            n_out.force_x = n_cf[0][31:0];
            n_out.force_y = n_cf[1][31:0];
            n_out.force_z = n_cf[2][31:0];
            n_out.energy  = n_cen[31:0];
            n_out.status  = n_csat ? ST_SAT : ST_OK;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_centre_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_CENTRE |->
            o_out_data.force_x == '0 && o_out_data.force_y == '0 &&
            o_out_data.force_z == '0 && o_out_data.energy == '0)
        else $error("centre result carries a nonzero value");

    a_dir_no_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_mode |-> o_out_data.status != ST_CENTRE)
        else $error("centre status in direction mode");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output is blocked");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status == ST_OK || o_out_data.status == ST_SAT ||
            o_out_data.status == ST_CENTRE)
        else $error("undefined status code");

endmodule

`default_nettype wire

### rtl/ref_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module ref_isqrt import ref_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_rad,
    input  wire t_sq_tag     i_tag,
    output logic             o_valid,
    output logic [31:0]      o_root,
    output t_sq_tag          o_tag
);

    localparam int STAGES = 32;

    logic [STAGES-1:0] r_v;
    logic [63:0]       r_rem  [STAGES];
    logic [63:0]       r_root [STAGES];
    t_sq_tag           r_tag  [STAGES];

    logic [63:0] p_rem  [STAGES];
    logic [63:0] p_root [STAGES];
    logic [63:0] n_rem  [STAGES];
    logic [63:0] n_root [STAGES];
    logic [63:0] n_trial[STAGES];
    logic [63:0] n_bit  [STAGES];

    always_comb begin
        p_rem[0]  = i_rad;
        p_root[0] = '0;
        for (int i = 1; i < STAGES; i++) begin
            p_rem[i]  = r_rem[i-1];
            p_root[i] = r_root[i-1];
        end
        for (int i = 0; i < STAGES; i++) begin
            n_bit[i]   = 64'd1 << (62 - 2 * i);
            n_trial[i] = p_root[i] + n_bit[i];
            if (p_rem[i] >= n_trial[i]) begin
                n_rem[i]  = p_rem[i] - n_trial[i];
                n_root[i] = (p_root[i] >> 1) + n_bit[i];
            end else begin
                n_rem[i]  = p_rem[i];
                n_root[i] = p_root[i] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < STAGES; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
            for (int i = 0; i < STAGES; i++) begin
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_root  = r_root[STAGES-1][31:0];
    assign o_tag   = r_tag[STAGES-1];

endmodule

`default_nettype wire

### rtl/ref_divu.sv
`timescale 1ns / 1ps
`default_nettype none

module ref_divu import ref_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [2:0][63:0] i_num,
    input  wire logic [32:0]      i_den,
    input  wire t_dv_tag          i_tag,
    output logic                  o_valid,
    output logic [2:0][31:0]      o_quo,
    output t_dv_tag               o_tag
);

    localparam int STAGES = 32;
    localparam int LANES  = 3;

    logic [STAGES-1:0]      r_v;
    logic [LANES-1:0][32:0] r_rem  [STAGES];
    logic [LANES-1:0][31:0] r_nlow [STAGES];
    logic [LANES-1:0][31:0] r_quo  [STAGES];
    logic [32:0]            r_den  [STAGES];
    t_dv_tag                r_tag  [STAGES];

    logic [LANES-1:0][32:0] p_rem  [STAGES];
    logic [LANES-1:0][31:0] p_nlow [STAGES];
    logic [LANES-1:0][31:0] p_quo  [STAGES];
    logic [32:0]            p_den  [STAGES];
    logic [LANES-1:0][32:0] n_rem  [STAGES];
    logic [LANES-1:0][31:0] n_quo  [STAGES];
    logic [33:0]            n_trial;

    always_comb begin
        n_trial = '0;
        p_den[0] = i_den;
        for (int l = 0; l < LANES; l++) begin
            p_rem[0][l]  = {1'b0, i_num[l][63:32]};
            p_nlow[0][l] = i_num[l][31:0];
            p_quo[0][l]  = '0;
        end
        for (int i = 1; i < STAGES; i++) begin
            p_den[i]  = r_den[i-1];
            p_rem[i]  = r_rem[i-1];
            p_nlow[i] = r_nlow[i-1];
            p_quo[i]  = r_quo[i-1];
        end
        for (int i = 0; i < STAGES; i++) begin
            for (int l = 0; l < LANES; l++) begin
                n_trial = {p_rem[i][l], p_nlow[i][l][31]};
                if (n_trial >= {1'b0, p_den[i]}) begin
                    n_rem[i][l] = 33'(n_trial - {1'b0, p_den[i]});
                    n_quo[i][l] = {p_quo[i][l][30:0], 1'b1};
                end else begin
                    n_rem[i][l] = n_trial[32:0];
                    n_quo[i][l] = {p_quo[i][l][30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < STAGES; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
            for (int i = 0; i < STAGES; i++) begin
                r_den[i] <= p_den[i];
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
                for (int l = 0; l < LANES; l++) begin
                    r_nlow[i][l] <= p_nlow[i][l] << 1;
                end
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];

endmodule

`default_nettype wire

### test/tb_ramped_external_force_core.sv
`timescale 1ns / 1ps

module tb_ramped_external_force_core;
    import ref_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int STEP_BITS = 32;
    localparam int DRAIN_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1650;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic        wr;
        logic [31:0] base;
        logic [31:0] rate;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        centre;
        t_in         item;
        logic        typed;
        t_out        want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    logic [31:0] reg_base, reg_rate, reg_vx, reg_vy, reg_vz;
    logic reg_centre;

    t_out force_due[$];
    logic typed_flag[$];
    t_out typed_value[$];
    t_row dir_tab[$];

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int centre_hits = 0;
    int sat_hits = 0;
    int idle_cnt = 0;
    logic jitter = 1'b1;

    ramped_external_force_core #(
        .FRAC_BITS(FRAC_BITS),
        .STEP_BITS(STEP_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_wide rnd_shift(input t_wide v, input int n);
        return (v + (t_wide'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic t_wide clamp32(input t_wide v, inout logic flag);
        if (v > t_wide'(64'sd2147483647)) begin
            flag = 1'b1;
            return t_wide'(64'sd2147483647);
        end
        if (v < t_wide'(-64'sd2147483648)) begin
            flag = 1'b1;
            return t_wide'(-64'sd2147483648);
        end
        return v;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_out force_of(input t_in x);
        t_out o;
        logic sat;
        t_wide s, stp, rate, dot, dst, q;
        t_wide vec[3];
        t_wide pos[3];
        t_wide d;
        logic [127:0] mag[3];
        logic [127:0] e[3];
        logic [127:0] m, sum, r, as;
        logic neg[3];
        logic kneg;
        int k;
        o = '0;
        sat = 1'b0;
        vec[0] = $signed(reg_vx);
        vec[1] = $signed(reg_vy);
        vec[2] = $signed(reg_vz);
        pos[0] = x.pos_x;
        pos[1] = x.pos_y;
        pos[2] = x.pos_z;
        stp = t_wide'({1'b0, x.step_count});
        rate = $signed(reg_rate);
        s = clamp32(t_wide'($signed(reg_base)) + rnd_shift(rate * stp, RATE_EXTRA), sat);
        if (!reg_centre) begin
            o.force_x = 32'(clamp32(rnd_shift(s * vec[0], FRAC_BITS), sat));
            o.force_y = 32'(clamp32(rnd_shift(s * vec[1], FRAC_BITS), sat));
            o.force_z = 32'(clamp32(rnd_shift(s * vec[2], FRAC_BITS), sat));
            dot = clamp32(rnd_shift(pos[0] * vec[0] + pos[1] * vec[1] + pos[2] * vec[2],
                FRAC_BITS), sat);
            o.energy = 32'(clamp32(-rnd_shift(s * dot, FRAC_BITS), sat));
        end else begin
            m = '0;
            for (int i = 0; i < 3; i++) begin
                d = vec[i] - pos[i];
                neg[i] = d < 0;
                mag[i] = d < 0 ? -d : d;
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                o.status = ST_CENTRE;
                return o;
            end
            kneg = m >= (128'd1 << 31);
            k = 0;
            if (kneg) begin
                for (int i = 0; i < 3; i++) e[i] = mag[i] >> 1;
            end else begin
                while ((m << k) < (128'd1 << 30)) k++;
                for (int i = 0; i < 3; i++) e[i] = mag[i] << k;
            end
            sum = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
            r = root64(sum[63:0]);
            if (kneg) dst = r << 1;
            else if (k == 0) dst = r;
            else dst = (r + (128'd1 << (k - 1))) >> k;
            if (dst > 2147483647) begin
                dst = 2147483647;
                sat = 1'b1;
            end
            o.energy = 32'(clamp32(-rnd_shift(s * dst, FRAC_BITS), sat));
            as = s < 0 ? -s : s;
            for (int i = 0; i < 3; i++) begin
                q = (2 * as * e[i] + r) / (2 * r);
                if ((s < 0) != neg[i]) q = -q;
                q = clamp32(q, sat);
                if (i == 0) o.force_x = 32'(q);
                else if (i == 1) o.force_y = 32'(q);
                else o.force_z = 32'(q);
            end
        end
        o.status = sat ? ST_SAT : ST_OK;
        return o;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= jitter && ($urandom_range(99) < 23);
    end

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            want = force_of(i_in_data);
            if (typed_flag.size() != 0 && typed_flag.pop_front()) want = typed_value.pop_front();
            force_due.push_back(want);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            results_seen++;
            if (force_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
            end else begin
                want = force_due.pop_front();
                if (got.status == ST_CENTRE) centre_hits++;
                if (got.status == ST_SAT) sat_hits++;
                if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
                    got.force_z !== want.force_z || got.energy !== want.energy ||
                    got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: fx %h/%h fy %h/%h fz %h/%h en %h/%h st %0d/%0d",
                            want.force_x, got.force_x, want.force_y, got.force_y,
                            want.force_z, got.force_z, want.energy, got.energy,
                            want.status, got.status);
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_empty();
        while (force_due.size() != 0 || typed_flag.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_cfg(input logic [31:0] b, input logic [31:0] r, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z, input logic c);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        reg_write(REG_BASE_FORCE, b);
        reg_write(REG_FORCE_RATE, r);
        reg_write(REG_VEC_X, x);
        reg_write(REG_VEC_Y, y);
        reg_write(REG_VEC_Z, z);
        reg_write(REG_CENTRE_MODE, {31'b0, c});
        i_cfg_we <= 1'b0;
        reg_base = b;
        reg_rate = r;
        reg_vx = x;
        reg_vy = y;
        reg_vz = z;
        reg_centre = c;
    endtask

    task automatic send(input t_in x, input logic typed, input t_out want);
        while (jitter && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_flag.push_back(typed);
        if (typed) typed_value.push_back(want);
        i_in_valid <= 1'b1;
        i_in_data <= x;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic add_row(input logic wr, input logic [31:0] b, input logic [31:0] r,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                           input logic c, input logic [31:0] stp, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz, input logic typed,
                           input logic [31:0] fx, input logic [31:0] fy,
                           input logic [31:0] fz, input logic [31:0] en,
                           input logic [1:0] st);
        t_row w;
        w.wr = wr;
        w.base = b;
        w.rate = r;
        w.vx = x;
        w.vy = y;
        w.vz = z;
        w.centre = c;
        w.item = '{step_count: stp, pos_x: px, pos_y: py, pos_z: pz};
        w.typed = typed;
        w.want = '{force_x: fx, force_y: fy, force_z: fz, energy: en, status: st};
        dir_tab.push_back(w);
    endtask

    function automatic logic [31:0] rnd_word(input logic [31:0] anchor);
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return anchor;
            3: return anchor + 32'($signed($urandom_range(64)) - 32);
            default: return anchor + 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [31:0] rnd_dir();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        localparam logic [31:0] MAXV = 32'h7fff_ffff;
        localparam logic [31:0] MINV = 32'h8000_0000;
        localparam logic [31:0] ONE = 32'h0001_0000;
        t_in x;
        logic [31:0] b, r;
        logic c;

        reg_base = '0;
        reg_rate = '0;
        reg_vx = ONE;
        reg_vy = '0;
        reg_vz = '0;
        reg_centre = 1'b0;

        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, MAXV, MINV, MAXV, 1, 0, 0, 0, 0, ST_OK);
        add_row(1, ONE, 0, ONE, 0, 0, 0, 5, 2 * ONE, 0, 0, 1,
                ONE, 0, 0, -32'sd131072, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, MAXV, MAXV, MAXV, MINV, MAXV, 0, 32'hffff_ffff, MAXV, MAXV, MAXV,
                0, 0, 0, 0, 0, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, 0, 1, MINV, MINV, MINV, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, MINV, MINV, MINV, MAXV, MINV, 0, 32'hffff_ffff, MINV, MINV, MINV,
                0, 0, 0, 0, 0, ST_OK);
        add_row(1, ONE, 0, ONE, 2 * ONE, 3 * ONE, 1, 7, ONE, 2 * ONE, 3 * ONE,
                1, 0, 0, 0, 0, ST_CENTRE);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 2 * ONE, 3 * ONE, 1, ONE, 0, 0, -ONE, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, 0, 3, MAXV, MAXV, MAXV, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, 0, 9, MINV, MINV, MINV, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 1, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, MAXV, MAXV, MAXV, MAXV, MAXV, 1, 32'hffff_ffff, MINV, MINV, MINV,
                0, 0, 0, 0, 0, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, MAXV, MAXV, MAXV, 1, 0, 0, 0, 0, ST_CENTRE);
        add_row(1, MINV, MINV, MINV, MINV, MINV, 1, 32'hffff_ffff, MAXV, MAXV, MAXV,
                0, 0, 0, 0, 0, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, 0, 2, MINV, MAXV, MINV, 0, 0, 0, 0, 0, ST_OK);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[n]) begin
            if (dir_tab[n].wr)
                set_cfg(dir_tab[n].base, dir_tab[n].rate, dir_tab[n].vx, dir_tab[n].vy,
                        dir_tab[n].vz, dir_tab[n].centre);
            send(dir_tab[n].item, dir_tab[n].typed, dir_tab[n].want);
        end

        // An index past the register list must leave the configuration alone.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        reg_write(3'd7, 32'hdead_beef);
        reg_write(3'd6, 32'h1234_5678);
        i_cfg_we <= 1'b0;
        send('{step_count: 11, pos_x: 32'sd5, pos_y: -32'sd7, pos_z: 32'sd9}, 0, '0);

        for (int ph = 0; ph < 10; ph++) begin
            c = ph[0];
            case ($urandom_range(3))
                0: b = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
                default: b = 32'($signed($urandom_range(1 << 24)) - (1 << 23));
            endcase
            case ($urandom_range(3))
                0: r = $urandom;
                1: r = 32'h0;
                default: r = 32'($signed($urandom_range(1 << 16)) - (1 << 15));
            endcase
            if (c) set_cfg(b, r, rnd_word(0), rnd_word(0), rnd_word(0), 1'b1);
            else set_cfg(b, r, rnd_dir(), rnd_dir(), rnd_dir(), 1'b0);
            jitter = (ph != 4);
            for (int n = 0; n < RANDOM_ITEMS / 10; n++) begin
                x.step_count = $urandom_range(1) ? $urandom : $urandom_range(4096);
                if (reg_centre && $urandom_range(15) == 0) begin
                    x.pos_x = reg_vx;
                    x.pos_y = reg_vy;
                    x.pos_z = reg_vz;
                end else begin
                    x.pos_x = rnd_word(reg_centre ? reg_vx : 32'h0);
                    x.pos_y = rnd_word(reg_centre ? reg_vy : 32'h0);
                    x.pos_z = rnd_word(reg_centre ? reg_vz : 32'h0);
                end
                send(x, 0, '0);
                if (n == 80 && ph == 2) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    wait_empty();
                end
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d items over both modes and many register settings.", items_sent);
        $display("Checked %0d results: %0d saturated, %0d at the centre, %0d mismatches.",
                 results_seen, sat_hits, centre_hits, mismatches);
        if (mismatches == 0 && force_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ref_pkg.sv
rtl/ref_isqrt.sv
rtl/ref_divu.sv
rtl/ramped_external_force_core.sv
test/tb_ramped_external_force_core.sv
